// ----- rtl/core/tbm_pkg.sv -----
package tbm_pkg;

    // Input request: source point, signed Q16.16
    typedef struct packed {
        logic signed [31:0] point_a;
        logic signed [31:0] point_b;
    } t_in;

    // Result request: mapped point and status
    typedef struct packed {
        logic signed [31:0] mapped_a;
        logic signed [31:0] mapped_b;
        logic [1:0]         map_status;
    } t_out;

    // map_status codes
    localparam logic [1:0] ST_MAPPED     = 2'd0;
    localparam logic [1:0] ST_DEGENERATE = 2'd1;
    localparam logic [1:0] ST_OUTSIDE    = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_CORNER0_SCREEN  = 3'd0;
    localparam logic [2:0] REG_CORNER1_SCREEN  = 3'd1;
    localparam logic [2:0] REG_CORNER2_SCREEN  = 3'd2;
    localparam logic [2:0] REG_CORNER0_TEXTURE = 3'd3;
    localparam logic [2:0] REG_CORNER1_TEXTURE = 3'd4;
    localparam logic [2:0] REG_CORNER2_TEXTURE = 3'd5;
    localparam logic [2:0] REG_MAP_DIRECTION   = 3'd6;
    localparam logic [2:0] REG_DEGEN_LIMIT     = 3'd7;

    localparam logic [31:0] DEGEN_LIMIT_RESET = 32'd43;

endpackage

// ----- rtl/core/triangle_barycentric_mapper_top.sv -----
// Barycentric triangle mapper. One point request is accepted every clock cycle unless
// o_in_stall is high, and each result passes through these stages in order: three
// stages form the four 2D determinants (differences, 33x33 multiplies, subtract), one
// stage checks degeneracy and signs, then one restoring-division stage per weight bit
// runs the three weight divisions side by side, and three stages blend, sum and
// floor/saturate the destination corners. A stall on the output freezes the whole pipe,
// which is seen on the input as o_in_stall. Corner, direction and limit registers are
// read live by the pipe, so the user must see they are written only while no request
// is in flight; the block itself does not enforce it. The config port is always ready.
module triangle_barycentric_mapper_top
    import tbm_pkg::*;
#(
    parameter int COORD_BITS       = 32,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int CB  = COORD_BITS;
    localparam int WF  = WEIGHT_FRAC_BITS;
    localparam int DFW = CB + 1;          // coordinate difference
    localparam int PW  = 2 * DFW;         // difference product
    localparam int DW  = PW + 1;          // determinant
    localparam int WW  = WF + 1;          // weight, Q1.WF unsigned
    localparam int BW  = WW + 1 + CB;     // weight times coordinate
    localparam int SW  = BW + 2;          // sum of three
    localparam int NST = WF + 7;          // pipeline stages

    localparam logic signed [SW-1:0] MAXV = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    typedef struct packed {
        logic [DW-1:0]         dmag;
        logic [2:0][DW-1:0]    rem;
        logic [2:0][WF-1:0]    q;
        logic [2:0]            clamp;
        logic [1:0]            status;
    } t_div;

    // Configuration registers
    logic [63:0] r_scr [3];
    logic [63:0] r_tex [3];
    logic        r_dir;
    logic [31:0] r_lim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_scr[k] <= '0;
                r_tex[k] <= '0;
            end
            r_dir <= 1'b0;
            r_lim <= DEGEN_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CORNER0_SCREEN:  r_scr[0] <= i_cfg_data;
                REG_CORNER1_SCREEN:  r_scr[1] <= i_cfg_data;
                REG_CORNER2_SCREEN:  r_scr[2] <= i_cfg_data;
                REG_CORNER0_TEXTURE: r_tex[0] <= i_cfg_data;
                REG_CORNER1_TEXTURE: r_tex[1] <= i_cfg_data;
                REG_CORNER2_TEXTURE: r_tex[2] <= i_cfg_data;
                REG_MAP_DIRECTION:   r_dir    <= i_cfg_data[0];
                REG_DEGEN_LIMIT:     r_lim    <= i_cfg_data[31:0];
                default:             r_dir    <= r_dir;
            endcase
        end
    end

    // Pipe advance: freeze everything while the result register is held
    logic en;
    logic [NST-1:0] r_vld;

    assign en         = !(r_vld[NST-1] && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // Source and destination corners
    logic signed [CB-1:0] sx [3];
    logic signed [CB-1:0] sy [3];
    logic signed [CB-1:0] ca [3];
    logic signed [CB-1:0] cb [3];
    logic signed [CB-1:0] px, py;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sx[k] = r_dir ? r_tex[k][32+CB-1:32] : r_scr[k][32+CB-1:32];
            sy[k] = r_dir ? r_tex[k][CB-1:0]     : r_scr[k][CB-1:0];
            ca[k] = r_dir ? r_scr[k][32+CB-1:32] : r_tex[k][32+CB-1:32];
            cb[k] = r_dir ? r_scr[k][CB-1:0]     : r_tex[k][CB-1:0];
        end
        px = i_in_data.point_a[CB-1:0];
        py = i_in_data.point_b[CB-1:0];
    end

    // Stage 1: differences; determinant m puts the point in place of corner m,
    // determinant 3 is the source triangle itself
    logic signed [CB-1:0]  tx [4][3];
    logic signed [CB-1:0]  ty [4][3];
    logic signed [DFW-1:0] n_dif [4][4];
    logic signed [DFW-1:0] r_dif [4][4];

    always_comb begin
        for (int m = 0; m < 4; m++) begin
            for (int k = 0; k < 3; k++) begin
                tx[m][k] = (m == k) ? px : sx[k];
                ty[m][k] = (m == k) ? py : sy[k];
            end
            n_dif[m][0] = DFW'(tx[m][1]) - DFW'(tx[m][0]);
            n_dif[m][1] = DFW'(ty[m][2]) - DFW'(ty[m][0]);
            n_dif[m][2] = DFW'(tx[m][2]) - DFW'(tx[m][0]);
            n_dif[m][3] = DFW'(ty[m][1]) - DFW'(ty[m][0]);
        end
    end

    // Stage 2: cross products
    logic signed [PW-1:0] n_prd [4][2];
    logic signed [PW-1:0] r_prd [4][2];

    always_comb begin
        for (int m = 0; m < 4; m++) begin
            n_prd[m][0] = r_dif[m][0] * r_dif[m][1];
            n_prd[m][1] = r_dif[m][2] * r_dif[m][3];
        end
    end

    // Stage 3: determinants
    logic signed [DW-1:0] n_det [4];
    logic signed [DW-1:0] r_det [4];

    always_comb begin
        for (int m = 0; m < 4; m++) begin
            n_det[m] = DW'(r_prd[m][0]) - DW'(r_prd[m][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dif <= n_dif;
            r_prd <= n_prd;
            r_det <= n_det;
        end
    end

    // Stage 4: degeneracy, sign and clamp checks, divider load
    t_div n_div [WF+1];
    t_div r_div [WF+1];
    logic [DW-1:0] dmag;
    logic [DW-1:0] nmag [3];
    logic          outside;
    logic          degen;
    logic [DW:0]   sh [WF][3];
    logic          ge [WF][3];

    always_comb begin
        dmag    = r_det[3][DW-1] ? DW'(-r_det[3]) : DW'(r_det[3]);
        degen   = (r_det[3] == '0) || (dmag < DW'(r_lim));
        outside = 1'b0;
        n_div[0].dmag = dmag;
        for (int i = 0; i < 3; i++) begin
            nmag[i] = r_det[i][DW-1] ? DW'(-r_det[i]) : DW'(r_det[i]);
            if ((r_det[i] != '0) && (r_det[i][DW-1] != r_det[3][DW-1])) begin
                outside = 1'b1;
            end
            n_div[0].rem[i]   = nmag[i];
            n_div[0].q[i]     = '0;
            n_div[0].clamp[i] = (nmag[i] >= dmag);
        end
        if (degen) begin
            n_div[0].status = ST_DEGENERATE;
        end else if (outside) begin
            n_div[0].status = ST_OUTSIDE;
        end else begin
            n_div[0].status = ST_MAPPED;
        end

        // Restoring division, one quotient bit per stage
        for (int j = 0; j < WF; j++) begin
            n_div[j+1].dmag   = r_div[j].dmag;
            n_div[j+1].clamp  = r_div[j].clamp;
            n_div[j+1].status = r_div[j].status;
            for (int i = 0; i < 3; i++) begin
                sh[j][i] = {r_div[j].rem[i], 1'b0};
                ge[j][i] = (sh[j][i] >= {1'b0, r_div[j].dmag});
                n_div[j+1].rem[i] = ge[j][i] ? DW'(sh[j][i] - {1'b0, r_div[j].dmag})
                                             : DW'(sh[j][i]);
                n_div[j+1].q[i]   = WF'({r_div[j].q[i], ge[j][i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div <= n_div;
        end
    end

    // Blend stage 1: weight times destination coordinate
    logic signed [WW:0]   w    [3];
    logic signed [BW-1:0] n_pa [3];
    logic signed [BW-1:0] n_pb [3];
    logic signed [BW-1:0] r_pa [3];
    logic signed [BW-1:0] r_pb [3];
    logic [1:0]           r_st1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w[i]    = r_div[WF].clamp[i] ? (WW+1)'(1) <<< WF
                                         : (WW+1)'({1'b0, r_div[WF].q[i]});
            n_pa[i] = w[i] * ca[i];
            n_pb[i] = w[i] * cb[i];
        end
    end

    // Blend stage 2: sums
    logic signed [SW-1:0] n_sa, n_sb;
    logic signed [SW-1:0] r_sa, r_sb;
    logic [1:0]           r_st2;

    always_comb begin
        n_sa = SW'(r_pa[0]) + SW'(r_pa[1]) + SW'(r_pa[2]);
        n_sb = SW'(r_pb[0]) + SW'(r_pb[1]) + SW'(r_pb[2]);
    end

    // Blend stage 3: floor to Q16.16, saturate, zero on fault
    logic signed [SW-1:0] fa, fb;
    logic signed [CB-1:0] ra, rb;
    t_out                 n_out;
    t_out                 r_out;

    always_comb begin
        fa = r_sa >>> WF;
        fb = r_sb >>> WF;
        if (fa > MAXV) begin
            ra = MAXV[CB-1:0];
        end else if (fa < MINV) begin
            ra = MINV[CB-1:0];
        end else begin
            ra = fa[CB-1:0];
        end
        if (fb > MAXV) begin
            rb = MAXV[CB-1:0];
        end else if (fb < MINV) begin
            rb = MINV[CB-1:0];
        end else begin
            rb = fb[CB-1:0];
        end
        n_out.map_status = r_st2;
        n_out.mapped_a   = (r_st2 == ST_MAPPED) ? 32'(ra) : '0;
        n_out.mapped_b   = (r_st2 == ST_MAPPED) ? 32'(rb) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa  <= n_pa;
            r_pb  <= n_pb;
            r_st1 <= r_div[WF].status;
            r_sa  <= n_sa;
            r_sb  <= n_sb;
            r_st2 <= r_st1;
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld[NST-1];
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/tbm_checker.sv -----
module tbm_checker
    import tbm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data,
    input logic o_cfg_ready
);

    // A held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Input is only stalled by a held result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // Status is one of the three codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.map_status == ST_MAPPED) ||
                        (o_out_data.map_status == ST_DEGENERATE) ||
                        (o_out_data.map_status == ST_OUTSIDE))
        else $error("bad map_status");

    // Fault results carry a zero point
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.map_status != ST_MAPPED) |->
            (o_out_data.mapped_a == '0) && (o_out_data.mapped_b == '0))
        else $error("nonzero point on fault");

    // Config port never blocks
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind triangle_barycentric_mapper_top tbm_checker u_tbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .o_cfg_ready (o_cfg_ready)
);
